### sv/thtp_pkg.sv
package thtp_pkg;

  localparam logic [7:0] SEP_CHAR       = 8'h5f;
  localparam logic [7:0] HEX_ALPHA_BASE = 8'd10;
  localparam int unsigned NIBBLE_BITS   = 4;

  localparam int unsigned ACC_W = 64;

  typedef struct packed {
    logic       cmd;
    logic [7:0] ch;
  } tok_req_t;

  typedef struct packed {
    logic             valid_res;
    logic [ACC_W-1:0] event_order;
    logic [ACC_W-1:0] membership_order;
    logic [ACC_W-1:0] stream_id;
  } res_req_t;

  typedef enum logic [1:0] {
    OP_DIGIT,
    OP_SEP,
    OP_BAD,
    OP_END
  } op_t;

  typedef struct packed {
    op_t                    op;
    logic [NIBBLE_BITS-1:0] digit;
  } cls_t;

endpackage

### sv/triple_hex_token_parser_top.sv
// triple hex token parser
// tok channel: one request per token character (cmd = 0, byte in ch) or an
// end-of-token request (cmd = 1). character requests give no result; each
// end request gives one res request with valid_res and the three hex field
// values (all zero when the token is malformed, stream_id zero when the third
// field is missing or empty).
// a request is taken on a rising edge with valid high and stall low.
// throughput: one tok request per cycle while tok_stall stays low.
// path: an end request passes the input classify register, then the queue,
// then the accumulate and output register before it shows up on res.
// the front classifies into a small queue of QUEUE_DEPTH entries; the back
// updates the accumulators and owns the output register. when res is
// stalled the back keeps taking character requests until an end request
// reaches the head of the queue, which then waits there; tok stalls only
// once the queue and the classify register are full.
// reset clears the parse state, the queue and the output valid.
module triple_hex_token_parser_top #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               tok_valid,
  output logic               tok_stall,
  input  thtp_pkg::tok_req_t tok,
  output logic               res_valid,
  input  logic               res_stall,
  output thtp_pkg::res_req_t res
);

  logic           push_valid;
  logic           push_ready;
  thtp_pkg::cls_t push_data;
  logic           pop_valid;
  logic           pop;
  thtp_pkg::cls_t pop_data;

  thtp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .tok_valid  (tok_valid),
    .tok_stall  (tok_stall),
    .tok        (tok),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  thtp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_data   (pop_data)
  );

  thtp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .ent_valid (pop_valid),
    .ent       (pop_data),
    .pop       (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

### sv/thtp_front.sv
module thtp_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               tok_valid,
  output logic               tok_stall,
  input  thtp_pkg::tok_req_t tok,
  output logic               push_valid,
  input  logic               push_ready,
  output thtp_pkg::cls_t     push_data
);

  logic           f_valid;
  thtp_pkg::cls_t f_cls;
  thtp_pkg::cls_t cls_next;
  logic           load;
  logic [7:0]     diff;

  // classify one request
  always_comb begin
    cls_next.op    = thtp_pkg::OP_BAD;
    cls_next.digit = '0;
    diff           = '0;
    if (tok.cmd) begin
      cls_next.op = thtp_pkg::OP_END;
    end else if (tok.ch == thtp_pkg::SEP_CHAR) begin
      cls_next.op = thtp_pkg::OP_SEP;
    end else if (tok.ch inside {[8'h30:8'h39]}) begin
      diff           = tok.ch - 8'h30;
      cls_next.op    = thtp_pkg::OP_DIGIT;
      cls_next.digit = diff[thtp_pkg::NIBBLE_BITS-1:0];
    end else if (tok.ch inside {[8'h61:8'h66]}) begin
      diff           = tok.ch - 8'h61 + thtp_pkg::HEX_ALPHA_BASE;
      cls_next.op    = thtp_pkg::OP_DIGIT;
      cls_next.digit = diff[thtp_pkg::NIBBLE_BITS-1:0];
    end else if (tok.ch inside {[8'h41:8'h46]}) begin
      diff           = tok.ch - 8'h41 + thtp_pkg::HEX_ALPHA_BASE;
      cls_next.op    = thtp_pkg::OP_DIGIT;
      cls_next.digit = diff[thtp_pkg::NIBBLE_BITS-1:0];
    end
  end

  assign load       = !f_valid || push_ready;
  assign tok_stall  = !load;
  assign push_valid = f_valid;
  assign push_data  = f_cls;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (load) begin
      f_valid <= tok_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && tok_valid) begin
      f_cls <= cls_next;
    end
  end

endmodule

### sv/thtp_queue.sv
module thtp_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  thtp_pkg::cls_t push_data,
  output logic           pop_valid,
  input  logic           pop,
  output thtp_pkg::cls_t pop_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  thtp_pkg::cls_t   entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count missed a push");
`endif

endmodule

### sv/thtp_back.sv
module thtp_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               ent_valid,
  input  thtp_pkg::cls_t     ent,
  output logic               pop,
  output logic               res_valid,
  input  logic               res_stall,
  output thtp_pkg::res_req_t res
);

  localparam int unsigned W = thtp_pkg::ACC_W;

  logic [1:0]         fidx,  fidx_next;
  logic [W-1:0]       acc0,  acc0_next;
  logic [W-1:0]       acc1,  acc1_next;
  logic [W-1:0]       acc2,  acc2_next;
  logic               seen0, seen0_next;
  logic               seen1, seen1_next;
  logic               bad,   bad_next;
  logic               res_valid_next;
  thtp_pkg::res_req_t res_next;
  logic               is_end;
  logic               ok;
  logic [W-1:0]       sel_acc;
  logic [W-1:0]       pushed;

  assign is_end = (ent.op == thtp_pkg::OP_END);
  assign pop    = ent_valid && (!is_end || !res_valid || !res_stall);
  assign ok     = !bad && seen0 && seen1;

  always_comb begin
    case (fidx)
      2'd0:    sel_acc = acc0;
      2'd1:    sel_acc = acc1;
      default: sel_acc = acc2;
    endcase
    pushed = (sel_acc << thtp_pkg::NIBBLE_BITS) + W'(ent.digit);
  end

  always_comb begin
    fidx_next      = fidx;
    acc0_next      = acc0;
    acc1_next      = acc1;
    acc2_next      = acc2;
    seen0_next     = seen0;
    seen1_next     = seen1;
    bad_next       = bad;
    res_valid_next = res_valid && res_stall;
    res_next       = res;
    if (pop) begin
      case (ent.op)
        thtp_pkg::OP_DIGIT: begin
          case (fidx)
            2'd0: begin
              acc0_next  = pushed;
              seen0_next = 1'b1;
            end
            2'd1: begin
              acc1_next  = pushed;
              seen1_next = 1'b1;
            end
            2'd2: begin
              acc2_next = pushed;
            end
            default: begin
            end
          endcase
        end
        thtp_pkg::OP_SEP: begin
          if (fidx < 2'd2) begin
            fidx_next = fidx + 2'd1;
          end else begin
            bad_next = 1'b1;
          end
        end
        thtp_pkg::OP_BAD: begin
          bad_next = 1'b1;
        end
        thtp_pkg::OP_END: begin
          res_valid_next            = 1'b1;
          res_next.valid_res        = ok;
          res_next.event_order      = ok ? acc0 : '0;
          res_next.membership_order = ok ? acc1 : '0;
          res_next.stream_id        = ok ? acc2 : '0;
          fidx_next                 = '0;
          acc0_next                 = '0;
          acc1_next                 = '0;
          acc2_next                 = '0;
          seen0_next                = 1'b0;
          seen1_next                = 1'b0;
          bad_next                  = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fidx      <= '0;
      acc0      <= '0;
      acc1      <= '0;
      acc2      <= '0;
      seen0     <= 1'b0;
      seen1     <= 1'b0;
      bad       <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      fidx      <= fidx_next;
      acc0      <= acc0_next;
      acc1      <= acc1_next;
      acc2      <= acc2_next;
      seen0     <= seen0_next;
      seen1     <= seen1_next;
      bad       <= bad_next;
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

`ifndef SYNTHESIS
  a_fidx_range: assert property (@(posedge clk) disable iff (rst)
    fidx != 2'd3)
    else $error("field index out of range");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (pop && is_end) |=> (fidx == '0 && !bad && !seen0 && !seen1))
    else $error("parse state not cleared after end");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.valid_res) |->
      (res.event_order == '0 && res.membership_order == '0 && res.stream_id == '0))
    else $error("invalid token carries nonzero fields");
`endif

endmodule

### bench/tb_top.sv
module tb_top;

  localparam int IDLE_LIMIT = 2000;
  localparam int TARGET_ITEMS = 950;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               tok_valid = 1'b0;
  logic               tok_stall;
  thtp_pkg::tok_req_t tok = '0;
  logic               res_valid;
  logic               res_stall = 1'b0;
  thtp_pkg::res_req_t res;

  thtp_pkg::tok_req_t pending[$];
  thtp_pkg::res_req_t expected_parses[$];
  thtp_pkg::res_req_t want_res;

  logic        tok_taken = 1'b0;
  int          tok_gap = 0;
  bit          tok_calm = 1'b0;
  int          res_hold = 0;
  bit          res_calm = 1'b0;
  int          mismatches = 0;
  int          idle_cycles = 0;

  // parse state mirrored from the block
  logic [1:0]  field_pos = '0;
  logic [63:0] acc_first = '0;
  logic [63:0] acc_second = '0;
  logic [63:0] acc_third = '0;
  logic        got_first = 1'b0;
  logic        got_second = 1'b0;
  logic        malformed = 1'b0;

  triple_hex_token_parser_top dut (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (tok_valid),
    .tok_stall (tok_stall),
    .tok       (tok),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  always #6 clk = ~clk;

  function automatic thtp_pkg::cls_t classify_byte(logic [7:0] c);
    thtp_pkg::cls_t k;
    k.op = thtp_pkg::OP_BAD;
    k.digit = '0;
    if (c == thtp_pkg::SEP_CHAR) begin
      k.op = thtp_pkg::OP_SEP;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      k.op = thtp_pkg::OP_DIGIT;
      k.digit = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      k.op = thtp_pkg::OP_DIGIT;
      k.digit = 4'(c - 8'h61 + thtp_pkg::HEX_ALPHA_BASE);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      k.op = thtp_pkg::OP_DIGIT;
      k.digit = 4'(c - 8'h41 + thtp_pkg::HEX_ALPHA_BASE);
    end
    return k;
  endfunction

  task automatic parse_step(thtp_pkg::tok_req_t t);
    thtp_pkg::cls_t     k;
    thtp_pkg::res_req_t r;
    logic               ok;
    if (t.cmd) begin
      k.op = thtp_pkg::OP_END;
      k.digit = '0;
    end else begin
      k = classify_byte(t.ch);
    end
    case (k.op)
      thtp_pkg::OP_END: begin
        ok = !malformed && got_first && got_second;
        r.valid_res = ok;
        r.event_order = ok ? acc_first : '0;
        r.membership_order = ok ? acc_second : '0;
        r.stream_id = ok ? acc_third : '0;
        expected_parses.insert(expected_parses.size(), r);
        field_pos = '0;
        acc_first = '0;
        acc_second = '0;
        acc_third = '0;
        got_first = 1'b0;
        got_second = 1'b0;
        malformed = 1'b0;
      end
      thtp_pkg::OP_SEP: begin
        if (field_pos < 2'd2) begin
          field_pos = field_pos + 2'd1;
        end else begin
          malformed = 1'b1;
        end
      end
      thtp_pkg::OP_BAD: begin
        malformed = 1'b1;
      end
      default: begin
        case (field_pos)
          2'd0: begin
            acc_first = (acc_first << thtp_pkg::NIBBLE_BITS) + 64'(k.digit);
            got_first = 1'b1;
          end
          2'd1: begin
            acc_second = (acc_second << thtp_pkg::NIBBLE_BITS) + 64'(k.digit);
            got_second = 1'b1;
          end
          2'd2: begin
            acc_third = (acc_third << thtp_pkg::NIBBLE_BITS) + 64'(k.digit);
          end
          default: ;
        endcase
      end
    endcase
  endtask

  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 8);
    if (r < 95) return $urandom_range(9, 16);
    return $urandom_range(17, 24);
  endfunction

  function automatic logic [7:0] hex_glyph(int v);
    if (v < 10) return 8'(8'h30 + v);
    if ($urandom_range(0, 1) == 0) return 8'(8'h61 + v - 10);
    return 8'(8'h41 + v - 10);
  endfunction

  task automatic add_char(logic [7:0] c);
    thtp_pkg::tok_req_t t;
    t.cmd = 1'b0;
    t.ch = c;
    pending.insert(pending.size(), t);
  endtask

  task automatic add_end();
    thtp_pkg::tok_req_t t;
    t.cmd = 1'b1;
    t.ch = 8'($urandom_range(0, 255));
    pending.insert(pending.size(), t);
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
  endtask

  task automatic add_hex_field(int len);
    for (int i = 0; i < len; i++) add_char(hex_glyph($urandom_range(0, 15)));
  endtask

  task automatic add_noise(int len);
    int r;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 9);
      if (r < 4) add_char(hex_glyph($urandom_range(0, 15)));
      else if (r < 6) add_char(thtp_pkg::SEP_CHAR);
      else add_char(8'($urandom_range(0, 255)));
    end
  endtask

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
    end else if (!tok_valid || tok_taken) begin
      if (tok_gap > 0) begin
        tok_valid <= 1'b0;
        tok_gap--;
      end else if (pending.size() > 0) begin
        tok_valid <= 1'b1;
        tok <= pending.pop_front();
        tok_gap = pick_gap(tok_calm);
        if ($urandom_range(0, 149) == 0) tok_calm = !tok_calm;
      end else begin
        tok_valid <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(negedge clk) begin
    if (res_hold > 0) begin
      res_stall <= 1'b1;
      res_hold--;
    end else begin
      res_stall <= 1'b0;
      if (!res_calm && $urandom_range(0, 2) == 0) res_hold = pick_gap(1'b0);
      if ($urandom_range(0, 199) == 0) res_calm = !res_calm;
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    if (rst) begin
      tok_taken <= 1'b0;
    end else begin
      tok_taken <= tok_valid && !tok_stall;
      if (tok_valid && !tok_stall) parse_step(tok);
      if (res_valid && !res_stall) begin
        if (expected_parses.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result: valid=%0d %h %h %h", res.valid_res,
                     res.event_order, res.membership_order, res.stream_id);
          mismatches++;
        end else begin
          want_res = expected_parses.pop_front();
          if (res.valid_res !== want_res.valid_res ||
              res.event_order !== want_res.event_order ||
              res.membership_order !== want_res.membership_order ||
              res.stream_id !== want_res.stream_id) begin
            if (mismatches < 10)
              $display("mismatch: want valid=%0d %h %h %h got valid=%0d %h %h %h",
                       want_res.valid_res, want_res.event_order,
                       want_res.membership_order, want_res.stream_id,
                       res.valid_res, res.event_order, res.membership_order,
                       res.stream_id);
            mismatches++;
          end
        end
      end
      if ((tok_valid && !tok_stall) || (res_valid && !res_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("FAIL triple_hex_token_parser_top");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int kind;
    int start;
    int pick;
    // lower and upper case digits, third field missing
    add_text("aF_9");
    add_end();
    // empty third field
    add_text("0_f_");
    add_end();
    // empty first field
    add_text("_5");
    add_end();
    // no underscore at all
    add_text("7");
    add_end();
    // empty second field and a zero byte
    add_text("1_");
    add_char(8'h00);
    add_end();
    // third underscore and an all-ones byte
    add_text("E_b_c_");
    add_char(8'hff);
    add_end();
    // empty token
    add_end();

    while (pending.size() < TARGET_ITEMS) begin
      kind = $urandom_range(0, 9);
      start = pending.size();
      if (kind < 7) begin
        add_hex_field(pick_len());
        add_char(thtp_pkg::SEP_CHAR);
        add_hex_field(pick_len());
        case ($urandom_range(0, 2))
          0: ;
          1: add_char(thtp_pkg::SEP_CHAR);
          default: begin
            add_char(thtp_pkg::SEP_CHAR);
            add_hex_field(pick_len());
          end
        endcase
        // corrupt one character
        if (kind == 6) begin
          pick = $urandom_range(start, pending.size() - 1);
          pending[pick].ch = 8'($urandom_range(0, 255));
        end
      end else if (kind == 7) begin
        add_hex_field($urandom_range(0, 2));
        if ($urandom_range(0, 3) != 0) add_char(thtp_pkg::SEP_CHAR);
        add_hex_field($urandom_range(0, 2));
        if ($urandom_range(0, 1) == 0) add_char(thtp_pkg::SEP_CHAR);
        add_hex_field($urandom_range(0, 2));
      end else begin
        add_noise($urandom_range(0, 10));
      end
      add_end();
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending.size() > 0 || tok_valid) @(posedge clk);
    while (expected_parses.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_parses.size() == 0) begin
      $display("PASS triple_hex_token_parser_top");
    end else begin
      $display("FAIL triple_hex_token_parser_top");
    end
    $finish;
  end

endmodule
